// ===== rtl/piezo_hit_gate_envelope_defines.svh =====
// assertion macros for the checker file of the piezo hit gate
`ifndef PIEZO_HIT_GATE_ENVELOPE_DEFINES_SVH
`define PIEZO_HIT_GATE_ENVELOPE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define PHGE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define PHGE_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/phge_pkg.sv =====
// shared types and constants of the piezo hit gate and gain envelope
package phge_pkg;

	// field widths
	localparam int SampleW  = 12;
	localparam int TimeW    = 32;
	localparam int LevelW   = 14;
	localparam int GainW    = 16;
	localparam int AlphaW   = 16;
	localparam int ThrW     = 13;
	localparam int MsW      = 16;

	// stream and register port widths
	localparam int InW      = 48;
	localparam int OutW     = 48;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 16;

	// shared multiplier
	localparam int MulW     = 18;
	localparam int ProdW    = 2 * MulW;

	// serial divider: 32-bit dividend, 16-bit divisor, one bit a cycle
	localparam int DivNumW  = 32;
	localparam int DivDenW  = 16;
	localparam int DivCntW  = 5;

	// unity gain in Q1.15
	localparam logic [GainW-1:0] GainOne = 16'h8000;

	// register reset values
	localparam logic [AlphaW-1:0] AlphaRst  = 16'd2621;
	localparam logic [ThrW-1:0]   ThrRst    = 13'd100;
	localparam logic [MsW-1:0]    WindowRst = 16'd20;
	localparam logic [MsW-1:0]    ReleaseRst = 16'd444;
	localparam logic [GainW-1:0]  FloorRst  = 16'd8192;

	// register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_ALPHA         = 3'd0,
		REG_HIT_THRESHOLD = 3'd1,
		REG_SCAN_WINDOW   = 3'd2,
		REG_RELEASE       = 3'd3,
		REG_FLOOR_GAIN    = 3'd4
	} cfg_reg_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_X,
		ST_MUL_AVG,
		ST_UPDATE,
		ST_SCAN,
		ST_RAMP,
		ST_MUL_RAMP,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_DONE
	} state_t;

	// operand selection of the shared multiplier
	typedef enum logic [1:0] {
		MUL_ALPHA_X,
		MUL_BETA_AVG,
		MUL_RAMP
	} mul_sel_t;

	// divider status towards the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== rtl/phge_mul.sv =====
// shared signed multiplier with registered product
module phge_mul (
	input  logic                                 clk,
	input  logic signed [phge_pkg::MulW-1:0]     op_a,
	input  logic signed [phge_pkg::MulW-1:0]     op_b,
	output logic signed [phge_pkg::ProdW-1:0]    prod_q
);
	import phge_pkg::*;

	// one product a cycle, product registered for the next cycle
	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

endmodule

// ===== rtl/phge_div.sv =====
// restoring serial divider, one quotient bit a cycle
module phge_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [phge_pkg::DivNumW-1:0]      dividend,
	input  logic [phge_pkg::DivDenW-1:0]      divisor,
	output logic [phge_pkg::DivDenW-1:0]      quot,
	output phge_pkg::div_stat_t               stat
);
	import phge_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DivCntW-1:0]   cnt_q;
	logic [DivDenW-1:0]   den_q;
	logic [DivDenW-1:0]   rem_q;
	logic [DivNumW-1:0]   dq_q;
	logic [DivDenW:0]     trial;
	logic                 ge;
	logic [DivDenW:0]     trial_sub;

	// trial subtract of the shifted remainder
	always_comb begin
		trial     = {rem_q, dq_q[DivNumW-1]};
		ge        = trial >= {1'b0, den_q};
		trial_sub = trial - {1'b0, den_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DivCntW'(DivNumW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: dividend shifts out at the top, quotient shifts in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= divisor;
			rem_q <= '0;
			dq_q  <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? trial_sub[DivDenW-1:0] : trial[DivDenW-1:0];
			dq_q  <= {dq_q[DivNumW-2:0], ge};
		end
	end

	assign quot      = dq_q[DivDenW-1:0];
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== rtl/piezo_hit_gate_envelope.sv =====
// piezo hit detector with a linear gain release envelope
//
// Each input item carries one 12-bit piezo sample and a millisecond time.
// The sample runs twice through an exponential-average high-pass that shares
// one average register, a hit fires when a scan above the threshold has run
// for the scan window, and after a hit the gain falls linearly from 1.0 to
// the floor gain over the release time. One result item per input item.
// The four filter products go through one shared 18x18 multiplier, so the
// sequencer takes no new item until the last one's result is formed; while
// the release ramp runs, one more multiply and a 32-step serial divide come
// before the gain update. s_tready is high only while the sequencer is idle;
// the result register lets the next item in while a finished result still
// waits for m_tready. Registers are taken at any time (cfg_ready is always
// high) but should be written only while no item is in flight.
module piezo_hit_gate_envelope (
	input  logic                              clk,
	input  logic                              arst_n,
	// sample[11:0], now_ms[43:12], zero fill[47:44]
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [phge_pkg::InW-1:0]          s_tdata,
	// filtered_sample[13:0], hit[14], peak_level[28:15], releasing[29],
	// gain[45:30], zero fill[47:46]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [phge_pkg::OutW-1:0]         m_tdata,
	// register writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [phge_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [phge_pkg::CfgDataW-1:0]     cfg_data
);
	import phge_pkg::*;

	localparam logic signed [20:0] SatHi = 21'sd8191;
	localparam logic signed [20:0] SatLo = -21'sd8192;
	localparam logic [AlphaW:0]    AlphaOne = 17'h10000;

	// saturate to the level range
	function automatic logic signed [LevelW-1:0] sat_level(input logic signed [20:0] v);
		logic signed [LevelW-1:0] r;
		if (v > SatHi) begin
			r = LevelW'(SatHi);
		end else if (v < SatLo) begin
			r = LevelW'(SatLo);
		end else begin
			r = v[LevelW-1:0];
		end
		return r;
	endfunction

	// registers
	logic [AlphaW-1:0]        alpha_q;
	logic [ThrW-1:0]          thr_q;
	logic [MsW-1:0]           window_q;
	logic [MsW-1:0]           release_q;
	logic [GainW-1:0]         floor_q;

	// envelope state
	logic signed [LevelW-1:0] avg_q;
	logic                     scanning_q;
	logic [TimeW-1:0]         scan_start_q;
	logic signed [LevelW-1:0] peak_q;
	logic                     ramp_on_q;
	logic [TimeW-1:0]         ramp_start_q;
	logic [GainW-1:0]         gain_q;

	// per-item working registers
	state_t                   state_q, state_d;
	logic signed [LevelW-1:0] x_q;
	logic [TimeW-1:0]         now_q;
	logic                     pass_q;
	logic                     hit_q;
	logic signed [ProdW-1:0]  acc_q;

	// result register
	logic                     out_valid_q;
	logic [OutW-1:0]          out_data_q;

	// sequencer outputs
	mul_sel_t                 mul_sel;
	logic                     div_start;
	logic                     out_load;
	logic                     accept;

	// datapath signals
	logic [GainW-1:0]         flo;
	logic [GainW-1:0]         span;
	logic [AlphaW:0]          beta;
	logic signed [MulW-1:0]   op_a, op_b;
	logic signed [ProdW-1:0]  prod_q;
	logic signed [ProdW-1:0]  num;
	logic [ProdW-1:0]         mag;
	logic [19:0]              qmag;
	logic signed [20:0]       q;
	logic signed [LevelW-1:0] avg_new;
	logic signed [20:0]       diff;
	logic signed [LevelW-1:0] y_new;
	logic                     above;
	logic [TimeW-1:0]         start_eff;
	logic signed [LevelW-1:0] peak_eff;
	logic [TimeW-1:0]         el_scan;
	logic                     in_win;
	logic [TimeW-1:0]         el_ramp;
	logic                     ramp_go;
	logic [DivDenW-1:0]       quot;
	div_stat_t                div_stat;

	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;

	// clamped floor and ramp depth
	assign flo  = (floor_q > GainOne) ? GainOne : floor_q;
	assign span = GainOne - flo;
	assign beta = AlphaOne - {1'b0, alpha_q};

	// operand selection for the shared multiplier
	always_comb begin
		unique case (mul_sel)
			MUL_ALPHA_X: begin
				op_a = {2'b00, alpha_q};
				op_b = MulW'(x_q);
			end
			MUL_BETA_AVG: begin
				op_a = {1'b0, beta};
				op_b = MulW'(avg_q);
			end
			MUL_RAMP: begin
				op_a = {2'b00, el_ramp[MsW-1:0]};
				op_b = {2'b00, span};
			end
			default: begin
				op_a = {2'b00, alpha_q};
				op_b = MulW'(x_q);
			end
		endcase
	end

	phge_mul u_mul (
		.clk    (clk),
		.op_a   (op_a),
		.op_b   (op_b),
		.prod_q (prod_q)
	);

	phge_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q[DivNumW-1:0]),
		.divisor  (release_q),
		.quot     (quot),
		.stat     (div_stat)
	);

	// average update, truncating toward zero, and high-pass output
	always_comb begin
		num     = acc_q + prod_q;
		mag     = num[ProdW-1] ? ProdW'(-num) : ProdW'(num);
		qmag    = mag[35:16];
		q       = num[ProdW-1] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
		avg_new = sat_level(q);
		diff    = 21'(x_q) - 21'(avg_new);
		y_new   = sat_level(diff);
	end

	// scan window and ramp timing
	always_comb begin
		above     = x_q > $signed({1'b0, thr_q});
		start_eff = scanning_q ? scan_start_q : now_q;
		peak_eff  = scanning_q ? peak_q : x_q;
		el_scan   = now_q - start_eff;
		in_win    = el_scan < {{(TimeW-MsW){1'b0}}, window_q};
		el_ramp   = now_q - ramp_start_q;
		ramp_go   = el_ramp < {{(TimeW-MsW){1'b0}}, release_q};
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (s_tvalid) state_d = ST_MUL_X;
			ST_MUL_X:     state_d = ST_MUL_AVG;
			ST_MUL_AVG:   state_d = ST_UPDATE;
			ST_UPDATE:    state_d = pass_q ? ST_SCAN : ST_MUL_X;
			ST_SCAN:      state_d = ST_RAMP;
			ST_RAMP:      state_d = (ramp_on_q && ramp_go) ? ST_MUL_RAMP : ST_DONE;
			ST_MUL_RAMP:  state_d = ST_DIV_START;
			ST_DIV_START: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT:  if (div_stat.done) state_d = ST_DONE;
			ST_DONE:      if (!out_valid_q || m_tready) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready  = 1'b0;
		mul_sel   = MUL_ALPHA_X;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE:      s_tready = 1'b1;
			ST_MUL_X:     mul_sel = MUL_ALPHA_X;
			ST_MUL_AVG:   mul_sel = MUL_BETA_AVG;
			ST_MUL_RAMP:  mul_sel = MUL_RAMP;
			ST_DIV_START: div_start = 1'b1;
			ST_DONE:      out_load = !out_valid_q || m_tready;
			default:      mul_sel = MUL_ALPHA_X;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q   <= AlphaRst;
			thr_q     <= ThrRst;
			window_q  <= WindowRst;
			release_q <= ReleaseRst;
			floor_q   <= FloorRst;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ALPHA:         alpha_q   <= cfg_data[AlphaW-1:0];
				REG_HIT_THRESHOLD: thr_q     <= cfg_data[ThrW-1:0];
				REG_SCAN_WINDOW:   window_q  <= cfg_data[MsW-1:0];
				REG_RELEASE:       release_q <= cfg_data[MsW-1:0];
				REG_FLOOR_GAIN:    floor_q   <= cfg_data[GainW-1:0];
				default:           ;
			endcase
		end
	end

	// envelope state and per-item control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q        <= '0;
			scanning_q   <= 1'b0;
			scan_start_q <= '0;
			peak_q       <= '0;
			ramp_on_q    <= 1'b0;
			ramp_start_q <= '0;
			gain_q       <= GainOne;
			pass_q       <= 1'b0;
			hit_q        <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pass_q <= 1'b0;
						hit_q  <= 1'b0;
					end
				end
				ST_UPDATE: begin
					avg_q  <= avg_new;
					pass_q <= ~pass_q;
				end
				ST_SCAN: begin
					if (above) begin
						scan_start_q <= start_eff;
						if (in_win) begin
							peak_q     <= (x_q > peak_eff) ? x_q : peak_eff;
							scanning_q <= 1'b1;
						end else begin
							peak_q       <= peak_eff;
							scanning_q   <= 1'b0;
							ramp_start_q <= now_q;
							ramp_on_q    <= 1'b1;
							hit_q        <= 1'b1;
						end
					end
				end
				ST_RAMP: begin
					if (ramp_on_q && !ramp_go) begin
						gain_q    <= flo;
						ramp_on_q <= 1'b0;
					end
				end
				ST_DIV_WAIT: begin
					if (div_stat.done) gain_q <= GainOne - quot;
				end
				default: ;
			endcase
		end
	end

	// item capture, filter input and first product
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q   <= LevelW'({2'b00, s_tdata[SampleW-1:0]});
			now_q <= s_tdata[SampleW +: TimeW];
		end else if (state_q == ST_UPDATE) begin
			x_q <= y_new;
		end
		if (state_q == ST_MUL_AVG) acc_q <= prod_q;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {2'b00, gain_q, ramp_on_q, peak_q, hit_q, x_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ===== rtl/piezo_hit_gate_envelope_chk.sv =====
// port checker for the piezo hit gate, bound to the top level
`include "piezo_hit_gate_envelope_defines.svh"

module piezo_hit_gate_envelope_chk (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic [phge_pkg::InW-1:0]          s_tdata,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [phge_pkg::OutW-1:0]         m_tdata,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [phge_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [phge_pkg::CfgDataW-1:0]     cfg_data
);
	import phge_pkg::*;

	// gain never exceeds unity
	`PHGE_ASSERT_IMP(a_gain_range, m_tvalid, m_tdata[45:30] <= GainOne, "gain above unity")

	// a hit restarts the ramp at full gain, or drops straight to the floor
	`PHGE_ASSERT_IMP(a_hit_gain, m_tvalid && m_tdata[14], m_tdata[45:30] == GainOne || !m_tdata[29], "hit without full gain")

	// s_tready is low straight after an accepted item
	`PHGE_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready right after an accepted item")

	// a stalled result holds
	`PHGE_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind piezo_hit_gate_envelope piezo_hit_gate_envelope_chk u_chk (.*);
